@@ sv/tmcr_pkg.sv @@
// Shared types, constants and codes for the text mode character renderer.
package tmcr_pkg;

  // Default store geometry
  localparam int unsigned SCREEN_WORDS_DEF = 2048;
  localparam int unsigned GLYPH_COUNT_DEF  = 2048;

  // Cell drawing width; pixels beyond the output width are dropped
  localparam int unsigned CELL_WIDTH = 10;
  localparam int unsigned PIX_W      = 10;
  localparam int unsigned WORD_W     = 16;
  localparam int unsigned ADDR_W     = 15;
  localparam int unsigned ROW_W      = 4;
  localparam int unsigned CODE_W     = 11;   // glyph index field of a screen word

  // Screen word attribute bits
  localparam int unsigned STRIKE_BIT  = 12;
  localparam int unsigned UNDER_BIT   = 13;
  localparam int unsigned INTENS_BIT  = 14;
  localparam int unsigned INVERT_BIT  = 15;
  // Glyph word fill-enable bits
  localparam int unsigned G_STRIKE_BIT = 14;
  localparam int unsigned G_UNDER_BIT  = 15;

  localparam logic [WORD_W-1:0] CELL_MASK =
      WORD_W'((17'd1 << CELL_WIDTH) - 17'd1);

  // Operation codes
  localparam logic [1:0] OP_SCREEN_WR = 2'd0;
  localparam logic [1:0] OP_GLYPH_WR  = 2'd1;
  localparam logic [1:0] OP_RENDER    = 2'd2;

  typedef struct packed {
    logic [1:0]        operation;
    logic [ADDR_W-1:0] address;
    logic [ROW_W-1:0]  glyph_row;
    logic [WORD_W-1:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_mask;
    logic             high_intensity;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADDR,
    ST_ADDR_Q,
    ST_ADDR_R,
    ST_CODE,
    ST_GIDX_Q,
    ST_GIDX_R,
    ST_SHADE,
    ST_DONE
  } tmcr_state_t;

endpackage

@@ sv/tmcr_ram.sv @@
// Generic single-clock RAM with one write port and a registered read port.
module tmcr_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/tmcr_wrap.sv @@
// Two-stage modulo reduction by the screen size or the glyph count.
module tmcr_wrap
  import tmcr_pkg::*;
#(
  parameter int unsigned SCREEN_WORDS = SCREEN_WORDS_DEF,
  parameter int unsigned GLYPH_COUNT  = GLYPH_COUNT_DEF,
  parameter int unsigned RW           = 11
) (
  input  logic              clk,
  input  logic              sel_glyph,
  input  logic [ADDR_W-1:0] x,
  output logic [RW-1:0]     r
);

  // Reciprocal constants: exact quotient for every x below 2**ADDR_W
  localparam int unsigned MW     = 17;
  localparam int unsigned NW     = 13;
  localparam int unsigned SCR_SH = ADDR_W + $clog2(SCREEN_WORDS);
  localparam int unsigned GLY_SH = ADDR_W + $clog2(GLYPH_COUNT);
  localparam logic [MW-1:0] SCR_M =
      MW'(((64'd1 << SCR_SH) + SCREEN_WORDS - 1) / SCREEN_WORDS);
  localparam logic [MW-1:0] GLY_M =
      MW'(((64'd1 << GLY_SH) + GLYPH_COUNT - 1) / GLYPH_COUNT);
  localparam logic [NW-1:0] SCR_N = NW'(SCREEN_WORDS);
  localparam logic [NW-1:0] GLY_N = NW'(GLYPH_COUNT);

  logic [ADDR_W+MW-1:0] prod;
  logic [ADDR_W-1:0]    q_next;
  logic [ADDR_W-1:0]    x_s1;
  logic [ADDR_W-1:0]    q_s1;
  logic                 sel_s1;
  logic [ADDR_W+NW-1:0] qn;
  logic [NW-1:0]        n_s1;
  logic [ADDR_W-1:0]    diff;
  logic [ADDR_W-1:0]    r_next;

  // Stage 1: quotient by reciprocal multiply
  always_comb begin
    prod = (ADDR_W+MW)'(x) * (ADDR_W+MW)'(sel_glyph ? GLY_M : SCR_M);
    if (sel_glyph) begin
      q_next = ADDR_W'(prod >> GLY_SH);
    end else begin
      q_next = ADDR_W'(prod >> SCR_SH);
    end
  end

  always_ff @(posedge clk) begin
    x_s1   <= x;
    q_s1   <= q_next;
    sel_s1 <= sel_glyph;
  end

  // Stage 2: remainder with one correction step
  always_comb begin
    n_s1   = sel_s1 ? GLY_N : SCR_N;
    qn     = (ADDR_W+NW)'(q_s1) * (ADDR_W+NW)'(n_s1);
    diff   = x_s1 - qn[ADDR_W-1:0];
    r_next = (diff >= ADDR_W'(n_s1)) ? diff - ADDR_W'(n_s1) : diff;
  end

  always_ff @(posedge clk) begin
    r <= r_next[RW-1:0];
  end

endmodule

@@ sv/text_mode_character_renderer.sv @@
// Top level: store access sequencer, screen and glyph stores, cell shading.
//
//   channel   signals                       direction  carries
//   in        in_valid / in_ready / in_item   in         operation, address, row, data
//   out       out_valid / out_ready / out_item out       pixel mask, intensity
//   cfg       cfg_valid / cfg_ready / cfg_data in        blank_display
//
// One item at a time: a write passes through ST_ADDR, ST_ADDR_Q, ST_ADDR_R and
// ST_DONE before the next item is taken; a render adds ST_CODE, ST_GIDX_Q,
// ST_GIDX_R and ST_SHADE. A render makes two passes through the shared two-stage
// modulo unit and two chained memory reads (screen word, then glyph word).
// Reset sets blank_display and clears the sequencer; stores are not cleared.
// A finished result sits in the output register, so the next item is taken
// while it waits; a stalled output holds the sequencer in its last state.
module text_mode_character_renderer
  import tmcr_pkg::*;
#(
  parameter int unsigned SCREEN_WORDS = SCREEN_WORDS_DEF,
  parameter int unsigned GLYPH_COUNT  = GLYPH_COUNT_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_data
);

  localparam int unsigned SCR_AW = $clog2(SCREEN_WORDS);
  localparam int unsigned GLY_IW = $clog2(GLYPH_COUNT);
  localparam int unsigned GLY_AW = GLY_IW + ROW_W;
  localparam int unsigned RW     = (SCR_AW > GLY_IW) ? SCR_AW : GLY_IW;

  tmcr_state_t       state, state_next;
  in_item_t          cur;
  logic [WORD_W-1:0] code;
  out_item_t         res;
  out_item_t         shade;
  logic              blank;
  logic              out_free;

  logic              wrap_sel;
  logic [ADDR_W-1:0] wrap_x;
  logic [RW-1:0]     wrap_r;

  logic              scr_we, scr_re;
  logic [WORD_W-1:0] scr_rdata;
  logic              gly_we, gly_re;
  logic [GLY_AW-1:0] gly_waddr, gly_raddr;
  logic [WORD_W-1:0] gly_rdata;

  logic              fill;
  logic [WORD_W-1:0] pix;

  assign out_free  = !out_valid || out_ready;
  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_valid) state_next = ST_ADDR;
      ST_ADDR:   state_next = ST_ADDR_Q;
      ST_ADDR_Q: state_next = ST_ADDR_R;
      ST_ADDR_R: state_next = (cur.operation == OP_RENDER) ? ST_CODE : ST_DONE;
      ST_CODE:   state_next = ST_GIDX_Q;
      ST_GIDX_Q: state_next = ST_GIDX_R;
      ST_GIDX_R: state_next = ST_SHADE;
      ST_SHADE:  state_next = ST_DONE;
      ST_DONE:   if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Store and modulo unit controls
  always_comb begin
    wrap_sel  = 1'b1;
    wrap_x    = ADDR_W'(scr_rdata[CODE_W-1:0]);
    scr_we    = 1'b0;
    scr_re    = 1'b0;
    gly_we    = 1'b0;
    gly_re    = 1'b0;
    gly_waddr = {wrap_r[GLY_IW-1:0], cur.address[ROW_W-1:0]};
    gly_raddr = {wrap_r[GLY_IW-1:0], cur.glyph_row};
    unique case (state)
      ST_ADDR: begin
        if (cur.operation == OP_GLYPH_WR) begin
          wrap_sel = 1'b1;
          wrap_x   = ADDR_W'(cur.address[ADDR_W-1:ROW_W]);
        end else begin
          wrap_sel = 1'b0;
          wrap_x   = cur.address;
        end
      end
      ST_ADDR_R: begin
        scr_we = (cur.operation == OP_SCREEN_WR);
        scr_re = (cur.operation == OP_RENDER);
        gly_we = (cur.operation == OP_GLYPH_WR);
      end
      ST_GIDX_R: gly_re = 1'b1;
      default: ;
    endcase
  end

  // Cell shading from the latched screen word and the fresh glyph word
  always_comb begin
    fill = (code[STRIKE_BIT] & gly_rdata[G_STRIKE_BIT]) |
           (code[UNDER_BIT]  & gly_rdata[G_UNDER_BIT]);
    pix  = fill ? CELL_MASK : (gly_rdata & CELL_MASK);
    if (code[INVERT_BIT]) begin
      pix = ~pix & CELL_MASK;
    end
    shade.pixel_mask     = blank ? '0 : pix[PIX_W-1:0];
    shade.high_intensity = blank ? 1'b0 : code[INTENS_BIT];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      blank     <= 1'b1;
    end else begin
      state <= state_next;
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid) begin
        blank <= cfg_data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cur <= in_item;
    end
    if (state == ST_CODE) begin
      code <= scr_rdata;
    end
    if (state == ST_ADDR_R) begin
      res <= '0;
    end else if (state == ST_SHADE) begin
      res <= shade;
    end
    if (state == ST_DONE && out_free) begin
      out_item <= res;
    end
  end

  tmcr_wrap #(
    .SCREEN_WORDS (SCREEN_WORDS),
    .GLYPH_COUNT  (GLYPH_COUNT),
    .RW           (RW)
  ) u_wrap (
    .clk       (clk),
    .sel_glyph (wrap_sel),
    .x         (wrap_x),
    .r         (wrap_r)
  );

  tmcr_ram #(
    .WIDTH (WORD_W),
    .DEPTH (SCREEN_WORDS)
  ) u_screen (
    .clk   (clk),
    .we    (scr_we),
    .waddr (wrap_r[SCR_AW-1:0]),
    .wdata (cur.write_data),
    .re    (scr_re),
    .raddr (wrap_r[SCR_AW-1:0]),
    .rdata (scr_rdata)
  );

  tmcr_ram #(
    .WIDTH (WORD_W),
    .DEPTH (GLYPH_COUNT * 16)
  ) u_glyph (
    .clk   (clk),
    .we    (gly_we),
    .waddr (gly_waddr),
    .wdata (cur.write_data),
    .re    (gly_re),
    .raddr (gly_raddr),
    .rdata (gly_rdata)
  );

endmodule
